// ===== rtl/core/dvr_pkg.sv =====
// Shared types, constants and helpers for the route update unit.
// No dependencies; dvr_if, dvr_eval and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package dvr_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int DEPTH     = MAX_NODES * MAX_NODES;
    localparam int CFG_W     = 5;
    localparam int DIST_W    = 5;
    localparam int OUT_DIST_W = 4;
    localparam int MODE_W    = 2;

    localparam logic [DIST_W-1:0] NO_ROUTE  = 5'd31;
    localparam logic [DIST_W-1:0] MAX_DIST  = 5'd15;
    localparam logic [DIST_W-1:0] LINK_DIST = 5'd1;

    localparam logic [MODE_W-1:0] MODE_LINK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHARE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_W-1:0] NODES_RESET = CFG_W'(MAX_NODES);

    typedef struct packed {
        logic [DIST_W-1:0] cost;
        logic [NODE_W-1:0] hop;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    typedef enum logic [1:0] {
        OP_LINK,
        OP_SHARE,
        OP_READ
    } eval_op_t;

    typedef struct packed {
        eval_op_t          op;
        route_entry_t      old_entry;
        route_entry_t      src_entry;
        logic [NODE_W-1:0] new_hop;
        logic              skip;
    } eval_req_t;

    typedef struct packed {
        logic         wr;
        logic         changed;
        logic         reach;
        route_entry_t entry;
    } eval_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LINK_RD,
        ST_LINK_WA,
        ST_LINK_WB,
        ST_SH_RUN,
        ST_SH_TAIL,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_FINISH
    } seq_state_t;

    // Value an entry holds before it is first written
    function automatic route_entry_t reset_entry(input logic [NODE_W-1:0] node,
                                                 input logic [NODE_W-1:0] dest);
        route_entry_t e;
        if (node == dest)
        begin
            e.cost = '0;
            e.hop  = node;
        end
        else
        begin
            e.cost = NO_ROUTE;
            e.hop  = '0;
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/dvr_if.sv =====
// Valid/ready channel interfaces: item input, result output, node count write.
// Depends on dvr_pkg for field widths.
`timescale 1ns / 1ps

interface dvr_item_if;
    logic                          valid;
    logic                          ready;
    logic [dvr_pkg::MODE_W-1:0]    mode;
    logic [dvr_pkg::NODE_W-1:0]    node_a;
    logic [dvr_pkg::NODE_W-1:0]    node_b;

    modport source (output valid, output mode, output node_a, output node_b, input ready);
    modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

interface dvr_result_if;
    logic                            valid;
    logic                            ready;
    logic [dvr_pkg::OUT_DIST_W-1:0]  distance;
    logic                            reachable;
    logic [dvr_pkg::NODE_W-1:0]      next_hop;
    logic [dvr_pkg::CNT_W-1:0]       updated_count;

    modport source (output valid, output distance, output reachable, output next_hop,
                    output updated_count, input ready);
    modport sink   (input valid, input distance, input reachable, input next_hop,
                    input updated_count, output ready);
endinterface

interface dvr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [dvr_pkg::CFG_W-1:0]   num_nodes;

    modport source (output valid, output num_nodes, input ready);
    modport sink   (input valid, input num_nodes, output ready);
endinterface

// ===== rtl/core/dvr_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

// ===== rtl/core/dvr_eval.sv =====
// Shared route evaluation unit: one increment, compare and change check.
// Depends on dvr_pkg for entry and request types.
`timescale 1ns / 1ps

module dvr_eval (
    input  dvr_pkg::eval_req_t req,
    output dvr_pkg::eval_rsp_t rsp
);

    logic [dvr_pkg::DIST_W:0] sum;
    logic                     take;
    dvr_pkg::route_entry_t    cand;

    always_comb
    begin
        sum  = {1'b0, req.src_entry.cost} + (dvr_pkg::DIST_W + 1)'(1);
        take = 1'b0;
        cand = req.old_entry;
        rsp  = '0;
        unique case (req.op)
            dvr_pkg::OP_LINK:
            begin
                cand.cost   = dvr_pkg::LINK_DIST;
                cand.hop    = req.new_hop;
                rsp.wr      = 1'b1;
                rsp.changed = (cand != req.old_entry);
            end
            dvr_pkg::OP_SHARE:
            begin
                // take a shorter route, or any route where there was none
                take = !req.skip
                    && (req.src_entry.cost != dvr_pkg::NO_ROUTE)
                    && (req.src_entry.cost != '0)
                    && (sum <= {1'b0, dvr_pkg::MAX_DIST})
                    && ((req.old_entry.cost == dvr_pkg::NO_ROUTE)
                        || (sum < {1'b0, req.old_entry.cost}));
                cand.cost   = sum[dvr_pkg::DIST_W-1:0];
                cand.hop    = req.new_hop;
                rsp.wr      = take;
                rsp.changed = take && (cand != req.old_entry);
            end
            dvr_pkg::OP_READ:
            begin
                rsp.reach = (req.old_entry.cost != dvr_pkg::NO_ROUTE);
            end
            default:
            begin
                rsp.wr = 1'b0;
            end
        endcase
        rsp.entry = cand;
    end

endmodule

// ===== rtl/core/distance_vector_route_update_unit.sv =====
// Distance-vector route update unit: sequencer, table RAM, shared evaluator.
// Link items pass through ST_LINK_RD, ST_LINK_WA and ST_LINK_WB, reads through ST_RD_ISSUE
// and ST_RD_DATA, shares through ST_SH_RUN and ST_SH_TAIL; an ignored item goes to ST_FINISH.
// Items are taken only in ST_IDLE, one at a time; a share walks one destination per cycle.
// The next item is taken while a finished result still waits in the output register.
// Reset clears the valid and neighbour bits at once; no clearing pass is needed.
// Depends on dvr_pkg, dvr_if, dvr_ram and dvr_eval.
`timescale 1ns / 1ps

module distance_vector_route_update_unit (
    input  logic                clk,
    input  logic                rst_n,
    dvr_item_if.sink            item,
    dvr_result_if.source        result,
    dvr_cfg_if.sink             cfg
);

    localparam int NW = dvr_pkg::NODE_W;
    localparam int AW = dvr_pkg::ADDR_W;
    localparam int CW = dvr_pkg::CNT_W;
    localparam int MN = dvr_pkg::MAX_NODES;

    // ------------------------------------------------------------------
    // Sequencer state and item registers
    // ------------------------------------------------------------------
    dvr_pkg::seq_state_t state_reg, state_next;

    logic [dvr_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [NW-1:0]              a_reg, a_next;
    logic [NW-1:0]              b_reg, b_next;
    logic [dvr_pkg::CFG_W-1:0]  num_nodes_reg;
    logic [CW-1:0]              n_use;

    // destination walk: issue counter and evaluation stage
    logic [CW-1:0]              issue_reg, issue_next;
    logic [CW-1:0]              issue_inc;
    logic                       ev_vld_reg, ev_vld_next;
    logic [NW-1:0]              ev_idx_reg, ev_idx_next;

    logic [CW-1:0]              count_reg, count_next;
    logic [dvr_pkg::OUT_DIST_W-1:0] pend_dist_reg, pend_dist_next;
    logic                       pend_reach_reg, pend_reach_next;
    logic [NW-1:0]              pend_hop_reg, pend_hop_next;

    // table storage: RAM plus one valid bit per entry
    logic [dvr_pkg::DEPTH-1:0]  valid_reg;
    logic                       vld0_reg, vld1_reg;
    logic [AW-1:0]              raddr0_reg, raddr1_reg;
    logic [MN-1:0][MN-1:0]      nb_reg;

    logic                       ram_re;
    logic [AW-1:0]              raddr0, raddr1;
    logic                       ram_we;
    logic [AW-1:0]              waddr;
    dvr_pkg::route_entry_t      wdata;
    logic [dvr_pkg::ENTRY_W-1:0] ram_q0, ram_q1;
    dvr_pkg::route_entry_t      rd0, rd1;

    logic                       nb_we;
    logic [NW-1:0]              nb_row, nb_col;

    dvr_pkg::eval_req_t         ev_req;
    dvr_pkg::eval_rsp_t         ev_rsp;

    // output register
    logic                       res_valid_reg;
    logic [dvr_pkg::OUT_DIST_W-1:0] res_distance_reg;
    logic                       res_reachable_reg;
    logic [NW-1:0]              res_next_hop_reg;
    logic [CW-1:0]              res_updated_count_reg;
    logic                       load_result;

    logic                       item_xfer;
    logic                       a_in_range, b_in_range;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign item.ready = (state_reg == dvr_pkg::ST_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid         = res_valid_reg;
    assign result.distance      = res_distance_reg;
    assign result.reachable     = res_reachable_reg;
    assign result.next_hop      = res_next_hop_reg;
    assign result.updated_count = res_updated_count_reg;

    // Clamp the configured count to the table size
    always_comb
    begin
        if (int'(num_nodes_reg) > MN)
        begin
            n_use = CW'(MN);
        end
        else
        begin
            n_use = CW'(num_nodes_reg);
        end
    end

    assign a_in_range = (CW'(item.node_a) < n_use);
    assign b_in_range = (CW'(item.node_b) < n_use);
    assign issue_inc  = issue_reg + CW'(1);

    // ------------------------------------------------------------------
    // Table RAM and the shared evaluator
    // ------------------------------------------------------------------
    dvr_ram #(
        .WIDTH (dvr_pkg::ENTRY_W),
        .DEPTH (dvr_pkg::DEPTH)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (waddr),
        .wdata  (wdata),
        .re     (ram_re),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (ram_q0),
        .rdata1 (ram_q1)
    );

    // an entry never written reads as its reset value
    assign rd0 = vld0_reg ? dvr_pkg::route_entry_t'(ram_q0)
                          : dvr_pkg::reset_entry(raddr0_reg[AW-1:NW], raddr0_reg[NW-1:0]);
    assign rd1 = vld1_reg ? dvr_pkg::route_entry_t'(ram_q1)
                          : dvr_pkg::reset_entry(raddr1_reg[AW-1:NW], raddr1_reg[NW-1:0]);

    dvr_eval u_eval (
        .req (ev_req),
        .rsp (ev_rsp)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dvr_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    // drop out-of-range, self-link and unused-mode items straight to the result
                    priority if ((item.mode == dvr_pkg::MODE_LINK) && a_in_range && b_in_range
                                 && (item.node_a != item.node_b))
                        state_next = dvr_pkg::ST_LINK_RD;
                    else if ((item.mode == dvr_pkg::MODE_SHARE) && a_in_range && b_in_range)
                        state_next = dvr_pkg::ST_SH_RUN;
                    else if ((item.mode == dvr_pkg::MODE_READ) && a_in_range && b_in_range)
                        state_next = dvr_pkg::ST_RD_ISSUE;
                    else
                        state_next = dvr_pkg::ST_FINISH;
                end
            end
            dvr_pkg::ST_LINK_RD:  state_next = dvr_pkg::ST_LINK_WA;
            dvr_pkg::ST_LINK_WA:  state_next = dvr_pkg::ST_LINK_WB;
            dvr_pkg::ST_LINK_WB:  state_next = dvr_pkg::ST_FINISH;
            dvr_pkg::ST_SH_RUN:
            begin
                if (issue_inc == n_use)
                begin
                    state_next = dvr_pkg::ST_SH_TAIL;
                end
            end
            dvr_pkg::ST_SH_TAIL:  state_next = dvr_pkg::ST_FINISH;
            dvr_pkg::ST_RD_ISSUE: state_next = dvr_pkg::ST_RD_DATA;
            dvr_pkg::ST_RD_DATA:  state_next = dvr_pkg::ST_FINISH;
            dvr_pkg::ST_FINISH:
            begin
                if (load_result)
                begin
                    state_next = dvr_pkg::ST_IDLE;
                end
            end
            default:              state_next = dvr_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: RAM control, evaluator request, register updates
    // ------------------------------------------------------------------
    always_comb
    begin
        ram_re          = 1'b0;
        raddr0          = '0;
        raddr1          = '0;
        ram_we          = 1'b0;
        waddr           = '0;
        wdata           = ev_rsp.entry;
        nb_we           = 1'b0;
        nb_row          = '0;
        nb_col          = '0;
        load_result     = 1'b0;
        mode_next       = mode_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        issue_next      = issue_reg;
        ev_vld_next     = ev_vld_reg;
        ev_idx_next     = ev_idx_reg;
        count_next      = count_reg;
        pend_dist_next  = pend_dist_reg;
        pend_reach_next = pend_reach_reg;
        pend_hop_next   = pend_hop_reg;

        ev_req.op        = dvr_pkg::OP_READ;
        ev_req.old_entry = rd0;
        ev_req.src_entry = rd0;
        ev_req.new_hop   = '0;
        ev_req.skip      = 1'b0;

        unique case (state_reg)
            dvr_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    // latch the item and clear the result under construction
                    mode_next       = item.mode;
                    a_next          = item.node_a;
                    b_next          = item.node_b;
                    issue_next      = '0;
                    ev_vld_next     = 1'b0;
                    count_next      = '0;
                    pend_dist_next  = '0;
                    pend_reach_next = 1'b0;
                    pend_hop_next   = '0;
                end
            end
            dvr_pkg::ST_LINK_RD:
            begin
                // fetch both old entries so the change count is exact
                ram_re = 1'b1;
                raddr0 = {a_reg, b_reg};
                raddr1 = {b_reg, a_reg};
            end
            dvr_pkg::ST_LINK_WA:
            begin
                ev_req.op        = dvr_pkg::OP_LINK;
                ev_req.old_entry = rd0;
                ev_req.new_hop   = b_reg;
                ram_we           = 1'b1;
                waddr            = {a_reg, b_reg};
                count_next       = count_reg + CW'(ev_rsp.changed);
                nb_we            = 1'b1;
                nb_row           = a_reg;
                nb_col           = b_reg;
            end
            dvr_pkg::ST_LINK_WB:
            begin
                // port 1 data held since the read in ST_LINK_RD
                ev_req.op        = dvr_pkg::OP_LINK;
                ev_req.old_entry = rd1;
                ev_req.new_hop   = a_reg;
                ram_we           = 1'b1;
                waddr            = {b_reg, a_reg};
                count_next       = count_reg + CW'(ev_rsp.changed);
                nb_we            = 1'b1;
                nb_row           = b_reg;
                nb_col           = a_reg;
            end
            dvr_pkg::ST_SH_RUN, dvr_pkg::ST_SH_TAIL:
            begin
                // evaluate the destination read last cycle: sender row on port 0,
                // receiver row on port 1
                ev_req.op        = dvr_pkg::OP_SHARE;
                ev_req.src_entry = rd0;
                ev_req.old_entry = rd1;
                ev_req.new_hop   = a_reg;
                ev_req.skip      = (ev_idx_reg == b_reg) || nb_reg[b_reg][ev_idx_reg];
                ram_we           = ev_vld_reg && ev_rsp.wr;
                waddr            = {b_reg, ev_idx_reg};
                if (ev_vld_reg)
                begin
                    count_next = count_reg + CW'(ev_rsp.changed);
                end
                if (state_reg == dvr_pkg::ST_SH_RUN)
                begin
                    // issue the next destination
                    ram_re      = 1'b1;
                    raddr0      = {a_reg, issue_reg[NW-1:0]};
                    raddr1      = {b_reg, issue_reg[NW-1:0]};
                    issue_next  = issue_inc;
                    ev_vld_next = 1'b1;
                    ev_idx_next = issue_reg[NW-1:0];
                end
                else
                begin
                    ev_vld_next = 1'b0;
                end
            end
            dvr_pkg::ST_RD_ISSUE:
            begin
                ram_re = 1'b1;
                raddr0 = {a_reg, b_reg};
            end
            dvr_pkg::ST_RD_DATA:
            begin
                ev_req.op        = dvr_pkg::OP_READ;
                ev_req.old_entry = rd0;
                pend_reach_next  = ev_rsp.reach;
                if (ev_rsp.reach)
                begin
                    pend_dist_next = ev_rsp.entry.cost[dvr_pkg::OUT_DIST_W-1:0];
                    pend_hop_next  = ev_rsp.entry.hop;
                end
            end
            dvr_pkg::ST_FINISH:
            begin
                // hold until the output register is free
                load_result = !res_valid_reg || result.ready;
            end
            default:
            begin
                load_result = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dvr_pkg::ST_IDLE;
            num_nodes_reg  <= dvr_pkg::NODES_RESET;
            mode_reg       <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            issue_reg      <= '0;
            ev_vld_reg     <= 1'b0;
            ev_idx_reg     <= '0;
            count_reg      <= '0;
            pend_dist_reg  <= '0;
            pend_reach_reg <= 1'b0;
            pend_hop_reg   <= '0;
            valid_reg      <= '0;
            nb_reg         <= '0;
            vld0_reg       <= 1'b0;
            vld1_reg       <= 1'b0;
            raddr0_reg     <= '0;
            raddr1_reg     <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            issue_reg      <= issue_next;
            ev_vld_reg     <= ev_vld_next;
            ev_idx_reg     <= ev_idx_next;
            count_reg      <= count_next;
            pend_dist_reg  <= pend_dist_next;
            pend_reach_reg <= pend_reach_next;
            pend_hop_reg   <= pend_hop_next;

            if (cfg.valid && cfg.ready)
            begin
                num_nodes_reg <= cfg.num_nodes;
            end
            if (ram_we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (nb_we)
            begin
                nb_reg[nb_row][nb_col] <= 1'b1;
            end
            if (ram_re)
            begin
                vld0_reg   <= valid_reg[raddr0];
                vld1_reg   <= valid_reg[raddr1];
                raddr0_reg <= raddr0;
                raddr1_reg <= raddr1;
            end

            if (load_result)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            res_distance_reg      <= pend_dist_reg;
            res_reachable_reg     <= pend_reach_reg;
            res_next_hop_reg      <= pend_hop_reg;
            res_updated_count_reg <= count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_only_when_updating: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == dvr_pkg::ST_LINK_WA) || (state_reg == dvr_pkg::ST_LINK_WB)
                    || (state_reg == dvr_pkg::ST_SH_RUN) || (state_reg == dvr_pkg::ST_SH_TAIL)))
        else $error("table written outside an update state");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MN))
        else $error("updated count exceeds node count");

    a_tail_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dvr_pkg::ST_SH_TAIL) |-> ev_vld_reg)
        else $error("share tail without an entry in evaluation");

    a_count_cleared_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer |=> (count_reg == '0))
        else $error("change count not cleared for a new item");

    a_share_writes_receiver_row: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != dvr_pkg::ST_LINK_WA) && (state_reg != dvr_pkg::ST_LINK_WB))
        |-> (waddr[AW-1:NW] == b_reg))
        else $error("share wrote outside the receiver row");

endmodule
